// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the detector RTL.
// ----------------------------------------------------------------------------
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: hw/rtl/dmpd_pkg.sv
// ----------------------------------------------------------------------------
// dmpd_pkg
// Shared types and constants of the multiple path detector.
// ----------------------------------------------------------------------------
`default_nettype none

package dmpd_pkg;

  localparam int CMD_W   = 2;
  localparam int NODE_W  = 6;
  localparam int COUNT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR     = 2'd0,
    CMD_ADD_EDGE  = 2'd1,
    CMD_EVALUATE  = 2'd2
  } dmpd_code_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_graph;
    logic edge_read;
    logic edge_write;
    logic eval_load;
    logic walk_init;
    logic node_read;
    logic node_expand;
    logic next_start;
    logic result_load;
  } dmpd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic edge_in_range;
    logic search_done;
    logic walk_empty;
    logic walk_hit;
    logic out_busy;
  } dmpd_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/dmpd_ctrl.sv
// ----------------------------------------------------------------------------
// dmpd_ctrl
// Controller state machine: decodes input words and sequences the walks.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dmpd_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [dmpd_pkg::CMD_W-1:0]  command,
  input  wire dmpd_pkg::dmpd_sts_t         sts,
  output dmpd_pkg::dmpd_cmd_t              cmd
);
  import dmpd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_EDGE_WR   = 6'b000010,
    S_WALK_INIT = 6'b000100,
    S_NODE_RD   = 6'b001000,
    S_EXPAND    = 6'b010000,
    S_OUT       = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          priority if (command == CMD_CLEAR) begin
            cmd.clear_graph = 1'b1;
          end else if (command == CMD_ADD_EDGE) begin
            // An edge with a node beyond the graph is dropped.
            if (sts.edge_in_range) begin
              cmd.edge_read = 1'b1;
              state_next    = S_EDGE_WR;
            end
          end else if (command == CMD_EVALUATE) begin
            cmd.eval_load = 1'b1;
            state_next    = S_WALK_INIT;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_EDGE_WR: begin
        cmd.edge_write = 1'b1;
        state_next     = S_IDLE;
      end
      S_WALK_INIT: begin
        if (sts.search_done) begin
          state_next = S_OUT;
        end else begin
          cmd.walk_init = 1'b1;
          state_next    = S_NODE_RD;
        end
      end
      S_NODE_RD: begin
        if (sts.walk_empty) begin
          cmd.next_start = 1'b1;
          state_next     = S_WALK_INIT;
        end else begin
          cmd.node_read = 1'b1;
          state_next    = S_EXPAND;
        end
      end
      S_EXPAND: begin
        cmd.node_expand = 1'b1;
        state_next      = sts.walk_hit ? S_WALK_INIT : S_NODE_RD;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `ASSERT_CLK(a_expand_after_read, cmd.node_expand |-> $past(cmd.node_read), "expand without read")
  `ASSERT_CLK(a_write_after_read, cmd.edge_write |-> $past(cmd.edge_read), "edge write without read")

endmodule

`default_nettype wire

// File: hw/rtl/dmpd_datapath.sv
// ----------------------------------------------------------------------------
// dmpd_datapath
// Adjacency memory, visited and pending masks, start counter and result word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dmpd_datapath #(
  parameter int MAX_NODES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [dmpd_pkg::NODE_W-1:0]   source_node,
  input  wire logic [dmpd_pkg::NODE_W-1:0]   target_node,
  input  wire logic [dmpd_pkg::COUNT_W-1:0]  node_count,
  input  wire dmpd_pkg::dmpd_cmd_t           cmd,
  output dmpd_pkg::dmpd_sts_t                sts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               has_multiple_paths
);
  import dmpd_pkg::*;

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);

  logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
  logic [MAX_NODES-1:0] row_valid;
  logic [MAX_NODES-1:0] rd_row;
  logic                 rd_row_valid;
  logic [MAX_NODES-1:0] row;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     pick;
  logic [IDX_W-1:0]     src_q;
  logic [IDX_W-1:0]     dst_q;
  logic [IDX_W-1:0]     cur_node;
  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     start_idx;
  logic [COUNT_W-1:0]   count_sat;
  logic [MAX_NODES-1:0] visited;
  logic [MAX_NODES-1:0] pending;
  logic                 found;
  logic                 dup_flag;

  // Lowest pending node is expanded next; the answer does not depend on order.
  always_comb begin
    pick = '0;
    for (int k = MAX_NODES - 1; k >= 0; k--) begin
      if (pending[k]) begin
        pick = IDX_W'(k);
      end
    end
  end

  assign rd_addr   = cmd.edge_read ? source_node[IDX_W-1:0] : pick;
  assign row       = rd_row & {MAX_NODES{rd_row_valid}};
  assign count_sat = (node_count > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES) : node_count;

  assign sts.edge_in_range = ({1'b0, source_node} < COUNT_W'(MAX_NODES)) &&
                             ({1'b0, target_node} < COUNT_W'(MAX_NODES));
  assign sts.search_done   = found || (start_idx >= count_q);
  assign sts.walk_empty    = (pending == '0);
  assign sts.walk_hit      = |(row & visited);
  assign sts.out_busy      = out_valid && !out_ready;

  // Adjacency memory: one read and one write port, read data registered.
  always_ff @(posedge clk) begin
    rd_row <= adj_mem[rd_addr];
    if (cmd.edge_write) begin
      adj_mem[src_q] <= row | (MAX_NODES'(1) << dst_q);
    end
  end

  // A row that has not been written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid    <= '0;
      rd_row_valid <= 1'b0;
    end else begin
      rd_row_valid <= row_valid[rd_addr];
      if (cmd.clear_graph) begin
        row_valid <= '0;
      end else if (cmd.edge_write) begin
        row_valid[src_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.edge_read) begin
      src_q <= source_node[IDX_W-1:0];
      dst_q <= target_node[IDX_W-1:0];
    end
    if (cmd.node_read) begin
      cur_node <= pick;
    end
    if (cmd.eval_load) begin
      count_q <= count_sat[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dup_flag           <= 1'b0;
      found              <= 1'b0;
      start_idx          <= '0;
      visited            <= '0;
      pending            <= '0;
      out_valid          <= 1'b0;
      has_multiple_paths <= 1'b0;
    end else begin
      if (cmd.clear_graph) begin
        dup_flag <= 1'b0;
      end else if (cmd.edge_write && row[dst_q]) begin
        dup_flag <= 1'b1;
      end

      if (cmd.eval_load) begin
        found     <= dup_flag;
        start_idx <= '0;
      end else if (cmd.next_start) begin
        start_idx <= start_idx + CNT_W'(1);
      end else if (cmd.node_expand && sts.walk_hit) begin
        found <= 1'b1;
      end

      if (cmd.walk_init) begin
        visited <= MAX_NODES'(1) << start_idx[IDX_W-1:0];
        pending <= MAX_NODES'(1) << start_idx[IDX_W-1:0];
      end else if (cmd.node_expand && !sts.walk_hit) begin
        visited <= visited | row;
        pending <= (pending & ~(MAX_NODES'(1) << cur_node)) | row;
      end

      if (cmd.result_load) begin
        out_valid          <= 1'b1;
        has_multiple_paths <= found;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_CLK(a_load_slot_free, cmd.result_load |-> (!out_valid || out_ready), "result overrun")
  `ASSERT_NEVER(a_pending_visited, (pending & ~visited) != '0, "pending node not visited")

endmodule

`default_nettype wire

// File: hw/rtl/dag_multiple_path_detector_unit.sv
// ----------------------------------------------------------------------------
// dag_multiple_path_detector_unit
// Detects two distinct paths between a node pair in a loaded directed graph.
// ----------------------------------------------------------------------------
// Words carry a command: clear, add edge (a read and then a write of the
// adjacency row; dropped if a node lies beyond the graph) or evaluate.
// After an evaluate word is taken the block is busy while it walks from each
// start node in turn; the whole search ends early on the first node reached
// twice. Each expanded node has its adjacency row read and then the visited
// and pending masks updated. One result word is given per evaluate, and a
// finished answer waits until any earlier result word has been collected,
// which lengthens the busy time. The block takes no new word while an edge
// or evaluation is in progress, but does take one while a result still
// waits to be collected.
`default_nettype none

module dag_multiple_path_detector_unit #(
  parameter int MAX_NODES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [dmpd_pkg::CMD_W-1:0]    command,
  input  wire logic [dmpd_pkg::NODE_W-1:0]   source_node,
  input  wire logic [dmpd_pkg::NODE_W-1:0]   target_node,
  input  wire logic [dmpd_pkg::COUNT_W-1:0]  node_count,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               has_multiple_paths
);
  import dmpd_pkg::*;

  dmpd_cmd_t cmd;
  dmpd_sts_t sts;

  dmpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .sts      (sts),
    .cmd      (cmd)
  );

  dmpd_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .source_node        (source_node),
    .target_node        (target_node),
    .node_count         (node_count),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .has_multiple_paths (has_multiple_paths)
  );

endmodule

`default_nettype wire

// File: dv/dmpd_answer_checker.sv
// ----------------------------------------------------------------------------
// dmpd_answer_checker
// Watches both channels of the multiple path detector, keeps its own copy of
// the loaded graph, predicts each evaluate answer and compares it on arrival.
// ----------------------------------------------------------------------------
`default_nettype none

module dmpd_answer_checker #(
  parameter int MAX_NODES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic [dmpd_pkg::CMD_W-1:0]    command,
  input  wire logic [dmpd_pkg::NODE_W-1:0]   source_node,
  input  wire logic [dmpd_pkg::NODE_W-1:0]   target_node,
  input  wire logic [dmpd_pkg::COUNT_W-1:0]  node_count,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic                          has_multiple_paths,
  output int                                 mismatches,
  output int                                 answers_due,
  output int                                 evals_predicted,
  output int                                 yes_predicted
);
  timeunit 1ns;
  timeprecision 1ps;
  import dmpd_pkg::*;

  localparam int REPORT_LIMIT = 10;

  logic [MAX_NODES-1:0] succ_rows [MAX_NODES];
  logic                 dup_seen;
  logic                 answer_queue [$];
  int                   fail_count = 0;
  int                   eval_count = 0;
  int                   yes_count  = 0;

  // Depth-first walk from one start node; true as soon as a node is reached
  // a second time.
  function automatic logic walk_revisits(input int start);
    logic [MAX_NODES-1:0] seen;
    int                   pending_nodes [MAX_NODES];
    int                   depth;
    int                   u;
    seen        = '0;
    seen[start] = 1'b1;
    pending_nodes[0] = start;
    depth = 1;
    while (depth > 0) begin
      depth--;
      u = pending_nodes[depth];
      for (int v = 0; v < MAX_NODES; v++) begin
        if (succ_rows[u][v]) begin
          if (seen[v]) return 1'b1;
          seen[v] = 1'b1;
          if (depth < MAX_NODES) begin
            pending_nodes[depth] = v;
            depth++;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic logic predict_answer(input logic [COUNT_W-1:0] count_in);
    int starts;
    starts = (int'(count_in) > MAX_NODES) ? MAX_NODES : int'(count_in);
    if (dup_seen) return 1'b1;
    for (int s = 0; s < starts; s++) begin
      if (walk_revisits(s)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("[%0t] %s", $time, msg);
  endfunction

  always @(posedge clk) begin : watch
    logic expected;
    if (rst) begin
      for (int r = 0; r < MAX_NODES; r++) succ_rows[r] = '0;
      dup_seen = 1'b0;
      answer_queue.delete();
    end else begin
      // The result side is handled first, so that a stray result word never
      // takes the answer of an evaluate accepted in the same cycle.
      if (out_valid && out_ready) begin
        if (answer_queue.size() == 0) begin
          note_failure($sformatf("result word with no evaluate pending: has_multiple_paths=%0b",
                                 has_multiple_paths));
        end else begin
          expected = answer_queue.pop_front();
          if (has_multiple_paths !== expected)
            note_failure($sformatf("has_multiple_paths: expected %0b, got %0b",
                                   expected, has_multiple_paths));
        end
      end
      if (in_valid && in_ready) begin
        case (command)
          CMD_CLEAR: begin
            for (int r = 0; r < MAX_NODES; r++) succ_rows[r] = '0;
            dup_seen = 1'b0;
          end
          CMD_ADD_EDGE: begin
            if (source_node < MAX_NODES && target_node < MAX_NODES) begin
              if (succ_rows[source_node][target_node]) dup_seen = 1'b1;
              succ_rows[source_node][target_node] = 1'b1;
            end
          end
          CMD_EVALUATE: begin
            expected = predict_answer(node_count);
            answer_queue = {answer_queue, expected};
            eval_count++;
            if (expected) yes_count++;
          end
          default: ;
        endcase
      end
    end
    mismatches      <= fail_count;
    answers_due     <= answer_queue.size();
    evals_predicted <= eval_count;
    yes_predicted   <= yes_count;
  end

endmodule

`default_nettype wire

// File: dv/dag_multiple_path_detector_unit_tb.sv
// ----------------------------------------------------------------------------
// dag_multiple_path_detector_unit_tb
// Drives edge loads and evaluate words into the detector, with random gaps on
// both channels, and leaves prediction and comparison to the answer checker.
// ----------------------------------------------------------------------------
`default_nettype none

module dag_multiple_path_detector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dmpd_pkg::*;

  localparam int               MAX_NODES     = 64;
  localparam logic [CMD_W-1:0] CMD_UNUSED    = 2'd3;
  localparam int               RANDOM_WORDS  = 1700;
  localparam int               IDLE_PERCENT  = 9;
  localparam int               CALM_FIRST    = 700;
  localparam int               CALM_LAST     = 1000;
  localparam int               SETTLE_CYCLES = 100;
  // Chosen to exceed the slowest evaluate by a wide margin.
  localparam int               STALL_LIMIT   = 40000;

  logic                clk;
  logic                rst                = 1'b1;
  logic                in_valid           = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    command            = '0;
  logic [NODE_W-1:0]   source_node        = '0;
  logic [NODE_W-1:0]   target_node        = '0;
  logic [COUNT_W-1:0]  node_count         = '0;
  logic                out_valid;
  logic                out_ready          = 1'b0;
  logic                has_multiple_paths;

  int   mismatches;
  int   answers_due;
  int   evals_predicted;
  int   yes_predicted;
  int   words_sent = 0;
  logic calm;

  dag_multiple_path_detector_unit #(
    .MAX_NODES(MAX_NODES)
  ) dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .command            (command),
    .source_node        (source_node),
    .target_node        (target_node),
    .node_count         (node_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .has_multiple_paths (has_multiple_paths)
  );

  dmpd_answer_checker #(
    .MAX_NODES(MAX_NODES)
  ) answer_check (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .command            (command),
    .source_node        (source_node),
    .target_node        (target_node),
    .node_count         (node_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .has_multiple_paths (has_multiple_paths),
    .mismatches         (mismatches),
    .answers_due        (answers_due),
    .evals_predicted    (evals_predicted),
    .yes_predicted      (yes_predicted)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // A stretch of words in the middle runs with neither side holding back.
  assign calm = (words_sent >= CALM_FIRST) && (words_sent < CALM_LAST);

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
  end

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] src,
                           input logic [NODE_W-1:0] dst, input logic [COUNT_W-1:0] cnt);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    source_node <= src;
    target_node <= dst;
    node_count  <= cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_noise();
    send_word(CMD_W'($urandom_range(3)), NODE_W'($urandom), NODE_W'($urandom),
              COUNT_W'($urandom));
  endtask

  // Clears, loads a random forest over n labels, which on its own has no node
  // reached twice, may add one disturbing edge, and evaluates, also at random.
  task automatic run_graph(input int n);
    int label [MAX_NODES];
    int from_node [MAX_NODES];
    int to_node [MAX_NODES];
    int n_edges;
    int j;
    int tmp;
    int pick;
    int cnt;
    send_word(CMD_CLEAR, NODE_W'($urandom), NODE_W'($urandom), COUNT_W'($urandom));
    for (int i = 0; i < n; i++) label[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = label[i];
      label[i] = label[j];
      label[j] = tmp;
    end
    n_edges = 0;
    for (int v = 1; v < n; v++) begin
      if ($urandom_range(9) < 8) begin
        from_node[n_edges] = label[$urandom_range(v - 1)];
        to_node[n_edges]   = label[v];
        n_edges++;
      end
    end
    for (int i = n_edges - 1; i > 0; i--) begin
      j            = $urandom_range(i);
      tmp          = from_node[i];
      from_node[i] = from_node[j];
      from_node[j] = tmp;
      tmp          = to_node[i];
      to_node[i]   = to_node[j];
      to_node[j]   = tmp;
    end
    for (int i = 0; i < n_edges; i++) begin
      send_word(CMD_ADD_EDGE, NODE_W'(from_node[i]), NODE_W'(to_node[i]), COUNT_W'($urandom));
      if ($urandom_range(19) == 0)
        send_word(CMD_EVALUATE, NODE_W'($urandom), NODE_W'($urandom), COUNT_W'(n));
    end
    case ($urandom_range(3))
      1: send_word(CMD_ADD_EDGE, NODE_W'($urandom_range(n - 1)), NODE_W'($urandom_range(n - 1)),
                   COUNT_W'($urandom));
      2: begin
        if (n_edges > 0) begin
          pick = $urandom_range(n_edges - 1);
          send_word(CMD_ADD_EDGE, NODE_W'(from_node[pick]), NODE_W'(to_node[pick]),
                    COUNT_W'($urandom));
        end
      end
      3: send_word(CMD_ADD_EDGE, NODE_W'($urandom_range(n - 1)), NODE_W'($urandom),
                   COUNT_W'($urandom));
      default: ;
    endcase
    case ($urandom_range(9))
      6, 7:    cnt = $urandom_range(n);
      8, 9:    cnt = $urandom_range(127, n);
      default: cnt = n;
    endcase
    send_word(CMD_EVALUATE, NODE_W'($urandom), NODE_W'($urandom), COUNT_W'(cnt));
    if ($urandom_range(9) < 3)
      send_word(CMD_EVALUATE, NODE_W'($urandom), NODE_W'($urandom),
                COUNT_W'($urandom_range(127)));
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("No word moved on either channel for %0d cycles.", STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int directed_words;
    int scenario;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Empty graph: no start node at all, then a count that saturates.
    send_word(CMD_EVALUATE, 6'd0, 6'd0, 7'd0);
    send_word(CMD_EVALUATE, 6'd63, 6'd63, 7'd127);
    // Two-node cycle between the extreme node numbers.
    send_word(CMD_ADD_EDGE, 6'd0, 6'd63, 7'd0);
    send_word(CMD_ADD_EDGE, 6'd63, 6'd0, 7'd127);
    send_word(CMD_EVALUATE, 6'd0, 6'd0, 7'd1);
    send_word(CMD_CLEAR, 6'd63, 6'd63, 7'd127);
    send_word(CMD_EVALUATE, 6'd0, 6'd0, 7'd64);
    // The same edge twice forces a yes even with no start node.
    send_word(CMD_ADD_EDGE, 6'd5, 6'd6, 7'd0);
    send_word(CMD_ADD_EDGE, 6'd5, 6'd6, 7'd0);
    send_word(CMD_EVALUATE, 6'd0, 6'd0, 7'd0);
    // The unused command must change nothing; the clear drops the flag.
    send_word(CMD_UNUSED, 6'd63, 6'd63, 7'd127);
    send_word(CMD_CLEAR, 6'd0, 6'd0, 7'd0);
    send_word(CMD_EVALUATE, 6'd0, 6'd0, 7'd1);
    // Diamond seen only by following edges into nodes at or above node_count.
    send_word(CMD_ADD_EDGE, 6'd0, 6'd1, 7'd0);
    send_word(CMD_ADD_EDGE, 6'd0, 6'd2, 7'd0);
    send_word(CMD_ADD_EDGE, 6'd1, 6'd3, 7'd0);
    send_word(CMD_ADD_EDGE, 6'd2, 6'd3, 7'd0);
    send_word(CMD_EVALUATE, 6'd0, 6'd0, 7'd1);
    send_word(CMD_EVALUATE, 6'd0, 6'd0, 7'd65);
    // Self loop on the top node.
    send_word(CMD_ADD_EDGE, 6'd63, 6'd63, 7'd0);
    send_word(CMD_EVALUATE, 6'd0, 6'd0, 7'd64);
    send_word(CMD_CLEAR, 6'd0, 6'd0, 7'd0);
    send_word(CMD_ADD_EDGE, 6'd63, 6'd62, 7'd0);
    send_word(CMD_EVALUATE, 6'd0, 6'd0, 7'd127);
    directed_words = words_sent;

    scenario = 0;
    while (words_sent < directed_words + RANDOM_WORDS) begin
      if (scenario % 40 == 17) run_graph(MAX_NODES);
      else run_graph($urandom_range(12, 2));
      repeat ($urandom_range(3)) send_noise();
      scenario++;
    end
    in_valid <= 1'b0;

    // Let the checker's count catch up with the last word before waiting on it.
    @(posedge clk);
    while (answers_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d input words over %0d random graphs after the directed part.",
             words_sent, scenario);
    $display("Checked %0d evaluate answers, %0d of them reporting multiple paths.",
             evals_predicted, yes_predicted);
    if (mismatches == 0 && answers_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
